>>> hdl/cte_pkg.sv
package cte_pkg;

   localparam int CAPACITY   = 64;
   localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int GROUP_SIZE = 8;
   localparam int SUB_W      = $clog2(GROUP_SIZE);
   localparam int GROUPS     = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int PAD_W      = GROUPS * GROUP_SIZE;

   localparam logic [15:0] CAP_ID_MAX = 16'(CAPACITY);
   localparam logic [15:0] XFER_MASK_RESET = 16'h0001;

   // operation codes
   localparam logic [2:0] OP_CREATE   = 3'd0;
   localparam logic [2:0] OP_VALIDATE = 3'd1;
   localparam logic [2:0] OP_COPY     = 3'd2;
   localparam logic [2:0] OP_DESCRIBE = 3'd3;
   localparam logic [2:0] OP_CLEAR    = 3'd4;

   // status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_BADARG  = 3'd1;
   localparam logic [2:0] ST_NOTUSED = 3'd2;
   localparam logic [2:0] ST_OWNER   = 3'd3;
   localparam logic [2:0] ST_NOXFER  = 3'd4;
   localparam logic [2:0] ST_EXCEED  = 3'd5;
   localparam logic [2:0] ST_FULL    = 3'd6;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] cap_id;
      logic [63:0] owner_id;
      logic [63:0] object_ref;
      logic [15:0] rights_req;
      logic [63:0] target_owner;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] new_id;
      logic [63:0] owner_out;
      logic [63:0] object_out;
      logic [15:0] rights_out;
      logic [15:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic [63:0] owner;
      logic [63:0] object;
      logic [15:0] rights;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic read;
      logic execute;
   } cmd_type;

endpackage

>>> hdl/cte_ctrl.sv
module cte_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output cte_pkg::cmd_type cmd
);
   import cte_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_READ = 3'b010,
      S_EXEC = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.read    = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_READ;
            end
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            // hold until the output register can take the result
            if (slot_free) begin
               cmd.execute = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hdl/cte_datapath.sv
module cte_datapath (
   input  logic             clock,
   input  logic             reset,
   input  cte_pkg::cmd_type cmd,
   input  cte_pkg::req_type req_data,
   input  logic             csr_write,
   input  logic [15:0]      csr_data,
   output cte_pkg::rsp_type rsp_data
);
   import cte_pkg::*;

   req_type               req_ff;
   rsp_type               rsp_ff, rsp_in;
   entry_type             mem [CAPACITY];
   entry_type             rd_ff;
   entry_type             wr_data;
   logic                  wr_en;
   logic [CAPACITY-1:0]   valid_ff, valid_in;
   logic [15:0]           count_ff, count_in;
   logic [15:0]           mask_ff;
   logic                  vbit_ff;
   logic [IDX_W-1:0]      idx;
   logic                  id_ok;
   logic [2:0]            xfer_st;

   // lowest free slot, two registered levels
   logic [PAD_W-1:0]      vpad;
   logic [GROUPS-1:0]     grp_free_ff, grp_free_in;
   logic [SUB_W-1:0]      grp_idx_ff [GROUPS];
   logic [SUB_W-1:0]      grp_idx_in [GROUPS];
   logic                  free_found_ff, free_found_in;
   logic [IDX_W-1:0]      free_idx_ff, free_idx_in;

   assign idx   = IDX_W'(req_ff.cap_id - 16'd1);
   assign id_ok = (req_ff.cap_id != 16'd0) && (req_ff.cap_id <= CAP_ID_MAX);

   always_comb begin
      vpad                 = '1;
      vpad[CAPACITY-1:0]   = valid_ff;
      for (int g = 0; g < GROUPS; g++) begin
         grp_free_in[g] = ~&vpad[g*GROUP_SIZE +: GROUP_SIZE];
         grp_idx_in[g]  = '0;
         for (int b = GROUP_SIZE - 1; b >= 0; b--) begin
            if (!vpad[g*GROUP_SIZE + b]) begin
               grp_idx_in[g] = SUB_W'(b);
            end
         end
      end
   end

   always_comb begin
      free_found_in = 1'b0;
      free_idx_in   = '0;
      for (int g = GROUPS - 1; g >= 0; g--) begin
         if (grp_free_ff[g]) begin
            free_found_in = 1'b1;
            free_idx_in   = IDX_W'(g * GROUP_SIZE) + IDX_W'(grp_idx_ff[g]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_free_ff   <= '1;
         free_found_ff <= 1'b1;
         free_idx_ff   <= '0;
      end else begin
         grp_free_ff   <= grp_free_in;
         free_found_ff <= free_found_in;
         free_idx_ff   <= free_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_idx_ff[g] <= grp_idx_in[g];
      end
   end

   // check sequence shared by validate and copy
   always_comb begin
      if (!id_ok || req_ff.rights_req == 16'd0) begin
         xfer_st = ST_BADARG;
      end else if (!vbit_ff) begin
         xfer_st = ST_NOTUSED;
      end else if (rd_ff.owner != req_ff.owner_id) begin
         xfer_st = ST_OWNER;
      end else if ((rd_ff.rights & mask_ff) == 16'd0) begin
         xfer_st = ST_NOXFER;
      end else if ((rd_ff.rights & req_ff.rights_req) != req_ff.rights_req) begin
         xfer_st = ST_EXCEED;
      end else begin
         xfer_st = ST_OK;
      end
   end

   always_comb begin
      rsp_in          = '0;
      rsp_in.status   = ST_BADARG;
      valid_in        = valid_ff;
      count_in        = count_ff;
      wr_en           = 1'b0;
      wr_data.owner   = req_ff.owner_id;
      wr_data.object  = req_ff.object_ref;
      wr_data.rights  = req_ff.rights_req;
      case (req_ff.op)
         OP_CREATE: begin
            if (req_ff.rights_req == 16'd0) begin
               rsp_in.status = ST_BADARG;
            end else if (!free_found_ff) begin
               rsp_in.status = ST_FULL;
            end else begin
               rsp_in.status         = ST_OK;
               rsp_in.new_id         = 16'(free_idx_ff) + 16'd1;
               wr_en                 = 1'b1;
               valid_in[free_idx_ff] = 1'b1;
               count_in              = count_ff + 16'd1;
            end
         end
         OP_VALIDATE: begin
            rsp_in.status = xfer_st;
         end
         OP_COPY: begin
            rsp_in.status = xfer_st;
            if (xfer_st == ST_OK) begin
               if (!free_found_ff) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  rsp_in.new_id         = 16'(free_idx_ff) + 16'd1;
                  wr_en                 = 1'b1;
                  wr_data.owner         = req_ff.target_owner;
                  wr_data.object        = rd_ff.object;
                  valid_in[free_idx_ff] = 1'b1;
                  count_in              = count_ff + 16'd1;
               end
            end
         end
         OP_DESCRIBE: begin
            if (!id_ok) begin
               rsp_in.status = ST_BADARG;
            end else if (!vbit_ff) begin
               rsp_in.status = ST_NOTUSED;
            end else begin
               rsp_in.status     = ST_OK;
               rsp_in.owner_out  = rd_ff.owner;
               rsp_in.object_out = rd_ff.object;
               rsp_in.rights_out = rd_ff.rights;
            end
         end
         OP_CLEAR: begin
            rsp_in.status = ST_OK;
            valid_in      = '0;
            count_in      = 16'd0;
         end
         default: begin
            rsp_in.status = ST_BADARG;
         end
      endcase
      rsp_in.entry_count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= 16'd0;
         mask_ff  <= XFER_MASK_RESET;
      end else begin
         if (cmd.execute) begin
            valid_ff <= valid_in;
            count_ff <= count_in;
         end
         if (csr_write) begin
            mask_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.read) begin
         rd_ff   <= mem[idx];
         vbit_ff <= valid_ff[idx];
      end
      if (cmd.execute && wr_en) begin
         mem[free_idx_ff] <= wr_data;
      end
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

>>> hdl/capability_table_engine.sv
// Sequence: accept the request, read the addressed entry, then execute into
//   the response register once it is free. A new request is accepted only
//   after execute, set by the single-port entry memory read-check-write sequence.
// Reset: synchronous, active high; frees every entry, zeroes the live count
//   and sets the transfer right mask to 1. No clearing pass is needed.
module capability_table_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cte_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cte_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [15:0]      csr_data
);
   import cte_pkg::*;

   // Command bundle from the sequencer into the datapath.
   cmd_type cmd;

   // The transfer mask register is always free to take a write; software
   // must write it only while the engine is idle, which the block does not check.
   assign csr_ready = 1'b1;

   // Sequencer: accept in idle, read the addressed entry, then execute and
   // load the output register. A pending result does not block the next
   // request transfer; execution alone waits for the output register.
   cte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Datapath: entry memory, valid bits, free-slot search tree, checks,
   // live count, transfer mask and the response register.
   cte_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   // one request in flight: accept drops ready for the next cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in flight");

   // live count never exceeds the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.entry_count <= CAP_ID_MAX))
      else $error("entry count beyond capacity");

   // a new id is reported only with success and lies within the table
   a_new_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.new_id != 16'd0) |->
         (rsp_data.status == ST_OK && rsp_data.new_id <= CAP_ID_MAX))
      else $error("bad new id in result");
`endif

endmodule

>>> bench/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import cte_pkg::*;

   // Op codes the block must reject without touching the table
   localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
   localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;

   localparam int MAX_REPORTS = 10;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data  = '0;

   capability_table_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow of the capability table, advanced once per request transfer
   // ---------------------------------------------------------------------
   logic        slot_live   [CAPACITY];
   logic [63:0] slot_owner  [CAPACITY];
   logic [63:0] slot_object [CAPACITY];
   logic [15:0] slot_rights [CAPACITY];
   logic [15:0] live_entries = '0;
   logic [15:0] xfer_mask    = XFER_MASK_RESET;

   initial begin
      foreach (slot_live[i]) begin
         slot_live[i]   = 1'b0;
         slot_owner[i]  = '0;
         slot_object[i] = '0;
         slot_rights[i] = '0;
      end
   end

   // Lowest free slot, or CAPACITY when the table is full
   function automatic int lowest_free_slot();
      for (int i = 0; i < CAPACITY; i++) begin
         if (!slot_live[i]) return i;
      end
      return CAPACITY;
   endfunction

   function automatic void claim_slot(int slot, logic [63:0] owner, logic [63:0] object,
                                      logic [15:0] rights);
      slot_live[slot]   = 1'b1;
      slot_owner[slot]  = owner;
      slot_object[slot] = object;
      slot_rights[slot] = rights;
      live_entries      = live_entries + 16'd1;
   endfunction

   function automatic logic id_in_range(logic [15:0] id);
      return id != 16'd0 && id <= CAP_ID_MAX;
   endfunction

   // Checks shared by validate and copy, in the order the block applies them
   function automatic logic [2:0] transfer_verdict(req_type r);
      int idx;
      if (!id_in_range(r.cap_id) || r.rights_req == 16'd0) return ST_BADARG;
      idx = int'(r.cap_id) - 1;
      if (!slot_live[idx]) return ST_NOTUSED;
      if (slot_owner[idx] != r.owner_id) return ST_OWNER;
      if ((slot_rights[idx] & xfer_mask) == 16'd0) return ST_NOXFER;
      if ((slot_rights[idx] & r.rights_req) != r.rights_req) return ST_EXCEED;
      return ST_OK;
   endfunction

   // Apply one request to the shadow table and return the response it earns
   function automatic rsp_type apply_request(req_type r);
      rsp_type     rsp;
      int          slot;
      int          idx;
      logic [63:0] source_object;
      rsp        = '0;
      rsp.status = ST_BADARG;
      case (r.op)
         OP_CREATE: begin
            if (r.rights_req != 16'd0) begin
               slot = lowest_free_slot();
               if (slot < CAPACITY) begin
                  claim_slot(slot, r.owner_id, r.object_ref, r.rights_req);
                  rsp.new_id = 16'(slot + 1);
                  rsp.status = ST_OK;
               end else begin
                  rsp.status = ST_FULL;
               end
            end
         end
         OP_VALIDATE: begin
            rsp.status = transfer_verdict(r);
         end
         OP_COPY: begin
            rsp.status = transfer_verdict(r);
            if (rsp.status == ST_OK) begin
               source_object = slot_object[int'(r.cap_id) - 1];
               slot = lowest_free_slot();
               if (slot < CAPACITY) begin
                  claim_slot(slot, r.target_owner, source_object, r.rights_req);
                  rsp.new_id = 16'(slot + 1);
               end else begin
                  rsp.status = ST_FULL;
               end
            end
         end
         OP_DESCRIBE: begin
            if (!id_in_range(r.cap_id)) begin
               rsp.status = ST_BADARG;
            end else begin
               idx = int'(r.cap_id) - 1;
               if (!slot_live[idx]) begin
                  rsp.status = ST_NOTUSED;
               end else begin
                  rsp.status     = ST_OK;
                  rsp.owner_out  = slot_owner[idx];
                  rsp.object_out = slot_object[idx];
                  rsp.rights_out = slot_rights[idx];
               end
            end
         end
         OP_CLEAR: begin
            foreach (slot_live[i]) begin
               slot_live[i]   = 1'b0;
               slot_owner[i]  = '0;
               slot_object[i] = '0;
               slot_rights[i] = '0;
            end
            live_entries = '0;
            rsp.status   = ST_OK;
         end
         default: rsp.status = ST_BADARG;
      endcase
      rsp.entry_count = live_entries;
      return rsp;
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: hold each item until its transfer, then advance
   // ---------------------------------------------------------------------
   req_type requests_to_send [$];
   rsp_type predicted_responses [$];
   logic    idling_on = 1'b1;
   int      send_gap  = 0;
   int      send_calm = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  = 0;
         send_calm = 0;
      end else if (!(req_valid && !req_ready)) begin
         // The lane is free: either nothing was offered or it has just transferred
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (requests_to_send.size() > 0) begin
            req_data  <= requests_to_send.pop_front();
            req_valid <= 1'b1;
            // Occasionally insert a burst of idle cycles after this item,
            // but leave calm stretches with back-to-back traffic
            if (send_calm > 0) begin
               send_calm--;
            end else if ($urandom_range(0, 39) == 0) begin
               send_calm = $urandom_range(20, 60);
            end else if (idling_on && $urandom_range(0, 3) == 0) begin
               send_gap = $urandom_range(1, 5);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: check each response transfer against the oldest prediction,
   // then predict for any request that transferred at the same edge
   // ---------------------------------------------------------------------
   rsp_type want;
   int      mismatches   = 0;
   int      result_index = 0;
   int      take_gap     = 0;
   int      take_calm    = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         take_gap  = 0;
         take_calm = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_responses.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("response %0d arrived with nothing outstanding: %p",
                           result_index, rsp_data);
            end else begin
               want = predicted_responses.pop_front();
               if (rsp_data.status      !== want.status     ||
                   rsp_data.new_id      !== want.new_id     ||
                   rsp_data.owner_out   !== want.owner_out  ||
                   rsp_data.object_out  !== want.object_out ||
                   rsp_data.rights_out  !== want.rights_out ||
                   rsp_data.entry_count !== want.entry_count) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS) begin
                     $display("response %0d expected status %0d id %0d owner %h",
                              result_index, want.status, want.new_id, want.owner_out);
                     $display("   object %h rights %h count %0d", want.object_out,
                              want.rights_out, want.entry_count);
                     $display("   got status %0d id %0d owner %h", rsp_data.status,
                              rsp_data.new_id, rsp_data.owner_out);
                     $display("   object %h rights %h count %0d", rsp_data.object_out,
                              rsp_data.rights_out, rsp_data.entry_count);
                  end
               end
            end
            result_index++;
         end

         if (req_valid && req_ready)
            predicted_responses.push_back(apply_request(req_data));

         if (csr_valid && csr_ready)
            xfer_mask = csr_data;

         // Stall the response side in short bursts
         if (take_gap > 0) begin
            take_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (take_calm > 0) begin
               take_calm--;
            end else if ($urandom_range(0, 49) == 0) begin
               take_calm = $urandom_range(20, 60);
            end else if (idling_on && $urandom_range(0, 4) == 0) begin
               take_gap = $urandom_range(1, 5);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   logic [63:0] owner_pool  [3];
   logic [15:0] rights_pool [4];

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   function automatic req_type make_request(logic [2:0] op, logic [15:0] id,
                                            logic [63:0] owner, logic [63:0] object,
                                            logic [15:0] rights, logic [63:0] target);
      req_type r;
      r.op           = op;
      r.cap_id       = id;
      r.owner_id     = owner;
      r.object_ref   = object;
      r.rights_req   = rights;
      r.target_owner = target;
      return r;
   endfunction

   // Mostly well-formed traffic: owners drawn from a small pool so that owner
   // checks pass often, ids biased towards the low slots that fill first,
   // requested rights often a subset of the rights handed out on create
   function automatic req_type random_request(int clear_per_mille);
      req_type r;
      int      pick;
      int      roll;
      pick = $urandom_range(0, 999);
      roll = $urandom_range(0, 99);
      r.cap_id = (roll < 3)  ? 16'd0 :
                 (roll < 6)  ? 16'($urandom_range(CAPACITY + 1, 65535)) :
                 (roll < 9)  ? CAP_ID_MAX :
                 (roll < 60) ? 16'($urandom_range(1, 12)) :
                               16'($urandom_range(1, CAPACITY));
      r.owner_id = ($urandom_range(0, 9) == 0) ? random_word()
                                               : owner_pool[$urandom_range(0, 2)];
      r.target_owner = ($urandom_range(0, 1) == 0) ? random_word()
                                                   : owner_pool[$urandom_range(0, 2)];
      r.object_ref = random_word();
      roll = $urandom_range(0, 99);
      r.rights_req = (roll < 5)  ? 16'd0 :
                     (roll < 20) ? 16'($urandom) :
                     (roll < 50) ? rights_pool[$urandom_range(0, 3)] :
                                   16'($urandom) & rights_pool[$urandom_range(0, 3)];
      if (pick < clear_per_mille) begin
         r.op = OP_CLEAR;
      end else if (pick < clear_per_mille + 15) begin
         r.op = 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
      end else begin
         roll = $urandom_range(0, 9);
         r.op = (roll < 3) ? OP_CREATE :
                (roll < 6) ? OP_VALIDATE :
                (roll < 8) ? OP_COPY : OP_DESCRIBE;
      end
      return r;
   endfunction

   // Wait until every item has transferred and every response is back,
   // sampling between edges so that the driver's updates have settled,
   // then let the pipeline settle
   task automatic wait_until_idle();
      @(negedge clock);
      while (requests_to_send.size() > 0 || predicted_responses.size() > 0 || req_valid)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_transfer_mask(input logic [15:0] mask);
      csr_data  <= mask;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_phase(input logic [15:0] mask, input int count,
                            input int clear_per_mille);
      write_transfer_mask(mask);
      owner_pool[2]  = random_word();
      rights_pool[3] = 16'($urandom) | mask;
      for (int i = 0; i < count; i++)
         requests_to_send.push_back(random_request(clear_per_mille));
      wait_until_idle();
   endtask

   localparam logic [63:0] ALL_ONES = '1;
   localparam logic [63:0] PEER     = 64'h0123_4567_89ab_cdef;

   initial begin
      owner_pool[0]  = '0;
      owner_pool[1]  = ALL_ONES;
      owner_pool[2]  = random_word();
      rights_pool[0] = 16'hffff;
      rights_pool[1] = 16'h00ff;
      rights_pool[2] = 16'hf00f;
      rights_pool[3] = 16'($urandom);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening under the reset transfer mask
      requests_to_send.push_back(make_request(OP_DESCRIBE, 16'd1, '0, '0, '0, '0));
      requests_to_send.push_back(make_request(OP_CREATE, 16'd0, PEER, PEER, 16'd0, '0));
      requests_to_send.push_back(make_request(OP_CREATE, 16'hffff, ALL_ONES, ALL_ONES,
                                              16'hffff, ALL_ONES));
      requests_to_send.push_back(make_request(OP_CREATE, 16'd0, '0, '0, 16'h0002, '0));
      requests_to_send.push_back(make_request(OP_DESCRIBE, 16'd0, '0, '0, '0, '0));
      requests_to_send.push_back(make_request(OP_DESCRIBE, CAP_ID_MAX + 16'd1,
                                              '0, '0, '0, '0));
      requests_to_send.push_back(make_request(OP_DESCRIBE, CAP_ID_MAX, '0, '0, '0, '0));
      requests_to_send.push_back(make_request(OP_DESCRIBE, 16'd1, '0, '0, '0, '0));
      requests_to_send.push_back(make_request(OP_VALIDATE, 16'd0, ALL_ONES, '0, 16'h1, '0));
      requests_to_send.push_back(make_request(OP_VALIDATE, 16'd1, ALL_ONES, '0, 16'h0, '0));
      requests_to_send.push_back(make_request(OP_VALIDATE, 16'd3, ALL_ONES, '0, 16'h1, '0));
      requests_to_send.push_back(make_request(OP_VALIDATE, 16'd1, '0, '0, 16'h1, '0));
      requests_to_send.push_back(make_request(OP_VALIDATE, 16'd2, '0, '0, 16'h2, '0));
      requests_to_send.push_back(make_request(OP_VALIDATE, 16'd1, ALL_ONES, '0,
                                              16'hffff, '0));
      requests_to_send.push_back(make_request(OP_COPY, 16'd1, ALL_ONES, '0, 16'h0003, PEER));
      requests_to_send.push_back(make_request(OP_VALIDATE, 16'd3, PEER, '0, 16'h0004, '0));
      requests_to_send.push_back(make_request(OP_COPY, 16'd2, '0, '0, 16'h0002, PEER));
      requests_to_send.push_back(make_request(OP_COPY, 16'hffff, ALL_ONES, '0, 16'h1, PEER));
      for (int op = OP_FIRST_UNUSED; op <= OP_LAST_UNUSED; op++)
         requests_to_send.push_back(make_request(3'(op), 16'd1, ALL_ONES, '0, 16'h1, '0));
      requests_to_send.push_back(make_request(OP_DESCRIBE, 16'd3, '0, '0, '0, '0));
      requests_to_send.push_back(make_request(OP_CLEAR, 16'd0, '0, '0, '0, '0));
      requests_to_send.push_back(make_request(OP_DESCRIBE, 16'd1, '0, '0, '0, '0));
      requests_to_send.push_back(make_request(OP_VALIDATE, 16'd1, ALL_ONES, '0, 16'h1, '0));
      wait_until_idle();

      // No clears in the first phase so that the table runs full
      run_phase(XFER_MASK_RESET, 250, 0);
      run_phase(16'hffff, 250, 8);
      // With an empty mask nothing can be transferred or copied
      run_phase(16'h0000, 150, 8);
      run_phase(16'($urandom), 250, 8);

      // Final stretch at full rate on both sides
      idling_on <= 1'b0;
      run_phase(16'h8000, 200, 5);

      repeat (8) @(posedge clock);
      if (mismatches == 0 && predicted_responses.size() == 0) begin
         $display("capability_table_engine: match");
      end else begin
         $display("capability_table_engine: mismatch");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("capability_table_engine: mismatch");
      $finish;
   end

endmodule
